[sv/ifcd_pkg.sv]
// ----------------------------------------------------------------------------
// ifcd_pkg
// Shared types, byte codes and colour helpers for the format code decoder.
// ----------------------------------------------------------------------------
package ifcd_pkg;

  // control bytes
  localparam logic [7:0] ByteBold   = 8'h02;
  localparam logic [7:0] ByteColour = 8'h03;
  localparam logic [7:0] ByteReset  = 8'h0f;
  localparam logic [7:0] ByteItalic = 8'h16;
  localparam logic [7:0] ByteLf     = 8'h0a;
  localparam logic [7:0] ByteComma  = 8'h2c;
  localparam logic [7:0] ByteZero   = 8'h30;
  localparam logic [7:0] ByteNine   = 8'h39;

  // digit field value meaning "no digits seen"
  localparam logic [6:0] NoDigits = 7'd127;

  localparam logic ItemChar  = 1'b0;
  localparam logic ItemBreak = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_START  = 3'd1,
    PH_FG_ONE = 3'd2,
    PH_FG_TWO = 3'd3,
    PH_COMMA  = 3'd4,
    PH_BG_ONE = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] char_out;
    logic [7:0] pair_code;
    logic       color_on;
    logic       bold_on;
    logic       ital_on;
    logic       last_of_run;
  } out_item_t;

  // colour state touched when a code completes
  typedef struct packed {
    logic [7:0] pair;
    logic       remembered;
    logic       shown;
  } colour_t;

  // work handed from front to back
  typedef struct packed {
    logic       brk;
    logic       chr;
    logic [7:0] ch;
    logic [7:0] pair;
    logic       shown;
    logic       bold;
    logic       italic;
  } job_t;

  // irc colour number (mod 16) to curses colour
  function automatic logic [3:0] curses_of(input logic [3:0] irc);
    logic [3:0] c;
    unique case (irc)
      4'd0:    c = 4'd15;
      4'd1:    c = 4'd0;
      4'd2:    c = 4'd4;
      4'd3:    c = 4'd2;
      4'd4:    c = 4'd9;
      4'd5:    c = 4'd1;
      4'd6:    c = 4'd5;
      4'd7:    c = 4'd3;
      4'd8:    c = 4'd11;
      4'd9:    c = 4'd10;
      4'd10:   c = 4'd6;
      4'd11:   c = 4'd14;
      4'd12:   c = 4'd12;
      4'd13:   c = 4'd13;
      4'd14:   c = 4'd8;
      default: c = 4'd7;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pair_of(input logic [6:0] fg, input logic [6:0] bg);
    logic [3:0] f;
    logic [3:0] b;
    if (fg == NoDigits) begin
      f = (bg == NoDigits) ? 4'd0 : 4'd7;
    end else begin
      f = curses_of(fg[3:0]);
    end
    b = (bg == NoDigits) ? 4'd0 : curses_of(bg[3:0]);
    return {b, f};
  endfunction

  // finish a colour code against the current colour state
  function automatic colour_t complete_code(input logic [6:0] fg, input logic [6:0] bg,
                                            input colour_t cur);
    colour_t    res;
    logic [7:0] t;
    res = cur;
    t   = pair_of(fg, bg);
    if (cur.remembered && (t != cur.pair)) begin
      res.shown = 1'b0;
    end
    if (fg != NoDigits) begin
      res.pair       = t;
      res.remembered = 1'b1;
      res.shown      = 1'b1;
    end
    return res;
  endfunction

endpackage

[sv/ifcd_front.sv]
// ----------------------------------------------------------------------------
// ifcd_front
// Parses incoming bytes, keeps attribute state and queues output work.
// ----------------------------------------------------------------------------
module ifcd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ifcd_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              push,
  output ifcd_pkg::job_t    push_data
);
  import ifcd_pkg::*;

  phase_t     phase_r, phase_nxt, phase_c;
  logic [6:0] fore_r, fore_nxt, fore_c;
  logic [6:0] back_r, back_nxt, back_c;
  colour_t    col_r, col_nxt, col_c;
  logic       bold_r, bold_nxt;
  logic       ital_r, ital_nxt;
  logic       nl_r, nl_nxt;

  logic       accept;
  logic [7:0] b;
  logic       eot;
  logic       digit;
  logic       comma;
  logic [3:0] d;
  logic       taken;
  logic       done;
  logic       brk;
  logic       chr;

  assign b      = in_data.text_byte;
  assign eot    = in_data.end_of_text;
  assign digit  = (b >= ByteZero) && (b <= ByteNine);
  assign comma  = (b == ByteComma);
  assign d      = b[3:0];
  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;

  // next phase of the colour code parser
  always_comb begin
    taken   = 1'b0;
    done    = 1'b0;
    phase_c = phase_r;
    if (phase_r != PH_IDLE) begin
      unique case (phase_r)
        PH_START: begin
          if (digit) begin
            phase_c = PH_FG_ONE;
            taken   = 1'b1;
          end else if (comma) begin
            phase_c = PH_COMMA;
            taken   = 1'b1;
          end else begin
            done = 1'b1;
          end
        end
        PH_FG_ONE: begin
          if (digit) begin
            phase_c = PH_FG_TWO;
            taken   = 1'b1;
          end else if (comma) begin
            phase_c = PH_COMMA;
            taken   = 1'b1;
          end else begin
            done = 1'b1;
          end
        end
        PH_FG_TWO: begin
          if (comma) begin
            phase_c = PH_COMMA;
            taken   = 1'b1;
          end else begin
            done = 1'b1;
          end
        end
        PH_COMMA: begin
          if (digit) begin
            phase_c = PH_BG_ONE;
            taken   = 1'b1;
          end else begin
            done = 1'b1;
          end
        end
        PH_BG_ONE: begin
          taken = digit;
          done  = 1'b1;
        end
        default: phase_c = PH_IDLE;
      endcase
    end
    if (done) begin
      phase_c = PH_IDLE;
    end
    phase_nxt = phase_c;
    if (!taken && (b == ByteColour)) begin
      phase_nxt = PH_START;
    end
    if (eot) begin
      phase_nxt = PH_IDLE;
    end
  end

  // digits, attributes and the work item
  always_comb begin
    fore_c = fore_r;
    back_c = back_r;
    if (digit) begin
      unique case (phase_r)
        PH_START:  fore_c = {3'b000, d};
        PH_FG_ONE: fore_c = fore_r * 7'd10 + {3'b000, d};
        PH_COMMA:  back_c = {3'b000, d};
        PH_BG_ONE: back_c = back_r * 7'd10 + {3'b000, d};
        default:   fore_c = fore_r;
      endcase
    end
    col_c = done ? complete_code(fore_c, back_c, col_r) : col_r;

    fore_nxt = fore_c;
    back_nxt = back_c;
    col_nxt  = col_c;
    bold_nxt = bold_r;
    ital_nxt = ital_r;
    nl_nxt   = nl_r;
    brk      = 1'b0;
    chr      = 1'b0;
    if (!taken) begin
      if (b == ByteLf) begin
        brk    = nl_r;
        nl_nxt = 1'b1;
      end else begin
        brk    = nl_r;
        nl_nxt = 1'b0;
        unique case (b)
          ByteColour: begin
            fore_nxt = NoDigits;
            back_nxt = NoDigits;
          end
          ByteBold:   bold_nxt = !bold_r;
          ByteItalic: ital_nxt = !ital_r;
          ByteReset: begin
            if (col_c.remembered) begin
              col_nxt = '0;
            end
            bold_nxt = 1'b0;
          end
          default: chr = 1'b1;
        endcase
      end
    end
    if (eot) begin
      col_nxt  = '0;
      bold_nxt = 1'b0;
      ital_nxt = 1'b0;
    end

    push_data.brk    = brk;
    push_data.chr    = chr;
    push_data.ch     = b;
    push_data.pair   = col_c.shown ? col_c.pair : 8'd0;
    push_data.shown  = col_c.shown;
    push_data.bold   = bold_r;
    push_data.italic = ital_r;
  end

  assign push = accept && (brk || chr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      fore_r  <= NoDigits;
      back_r  <= NoDigits;
      col_r   <= '0;
      bold_r  <= 1'b0;
      ital_r  <= 1'b0;
      nl_r    <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      fore_r  <= fore_nxt;
      back_r  <= back_nxt;
      col_r   <= col_nxt;
      bold_r  <= bold_nxt;
      ital_r  <= ital_nxt;
      nl_r    <= nl_nxt;
    end
  end

endmodule

[sv/ifcd_queue.sv]
// ----------------------------------------------------------------------------
// ifcd_queue
// Two-entry queue of work items between front and back.
// ----------------------------------------------------------------------------
module ifcd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ifcd_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output ifcd_pkg::job_t head
);
  import ifcd_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[sv/ifcd_back.sv]
// ----------------------------------------------------------------------------
// ifcd_back
// Turns queued work into one or two result transfers via an output register.
// ----------------------------------------------------------------------------
module ifcd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  ifcd_pkg::job_t     head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output ifcd_pkg::out_item_t out_data
);
  import ifcd_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      brk_sent_r, brk_sent_nxt;
  logic      load;
  logic      emit_brk;

  assign load     = head_valid && (!out_valid_r || out_ready);
  assign emit_brk = head.brk && !brk_sent_r;
  assign pop      = load && !(emit_brk && head.chr);

  always_comb begin
    out_data_nxt.pair_code = head.pair;
    out_data_nxt.color_on  = head.shown;
    out_data_nxt.bold_on   = head.bold;
    out_data_nxt.ital_on   = head.italic;
    if (emit_brk) begin
      out_data_nxt.item_kind   = ItemBreak;
      out_data_nxt.char_out    = 8'd0;
      out_data_nxt.last_of_run = !head.chr;
    end else begin
      out_data_nxt.item_kind   = ItemChar;
      out_data_nxt.char_out    = head.ch;
      out_data_nxt.last_of_run = 1'b1;
    end
    out_valid_nxt = load ? 1'b1 : (out_valid_r && !out_ready);
    brk_sent_nxt  = load ? (emit_brk && head.chr) : brk_sent_r;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      brk_sent_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      brk_sent_r  <= brk_sent_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/irc_format_code_decoder.sv]
// ----------------------------------------------------------------------------
// irc_format_code_decoder
// Decodes irc formatting codes in a byte stream and emits printable bytes
// and line breaks tagged with the colour, bold and italic attributes.
// ----------------------------------------------------------------------------
//
//   channel   signals                      carries
//   input     in_valid/in_ready/in_data    text byte, end-of-message flag
//   output    out_valid/out_ready/out_data one character or line break
//
// - one byte is taken per cycle while the queue is not full; the front parses
//   it in that cycle and queues at most one work item holding up to two results
// - the back drains one result per cycle while out_ready is high, so a byte
//   yielding a line break and a character takes two output transfers and the queue absorbs it
// - rst_n is synchronous: parser idle, attributes clear, queue and output
//   register empty
// - in_ready drops only while the two-entry queue is full
//
module irc_format_code_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ifcd_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ifcd_pkg::out_item_t out_data
);
  import ifcd_pkg::*;

  // front to queue
  logic q_full;
  logic push;
  job_t push_data;

  // queue to back
  logic pop;
  logic head_valid;
  job_t head;

  // parser and attribute state, one byte per transfer
  ifcd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // decouples parsing from output stalls
  ifcd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // splits each work item into result transfers
  ifcd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
